>>> hw/rtl/tcp_segment_reassembly_defines.svh
// assertion helpers for the reassembly block
`ifndef TCP_SEGMENT_REASSEMBLY_DEFINES_SVH
`define TCP_SEGMENT_REASSEMBLY_DEFINES_SVH

`ifndef SYNTHESIS
`define TSR_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("tsr assertion failed");
`define TSR_ASSERT_NEXT(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error("tsr assertion failed");
`else
`define TSR_ASSERT(label, clk, rst_n, prop)
`define TSR_ASSERT_NEXT(label, clk, rst_n, pre, post)
`endif

`endif

>>> hw/rtl/tsr_pkg.sv
package tsr_pkg;

	typedef enum logic [1:0] {
		KIND_DATA   = 2'd0,
		KIND_GAP    = 2'd1,
		KIND_EOS    = 2'd2,
		KIND_STATUS = 2'd3
	} tsr_kind_t;

	typedef enum logic {
		OP_SEGMENT = 1'b0,
		OP_EOS     = 1'b1
	} tsr_opcode_t;

	typedef enum logic [1:0] {
		TBL_NONE,
		TBL_INSERT,
		TBL_POP
	} tsr_tbl_op_t;

	typedef struct packed {
		logic [31:0] seq;
		logic [15:0] len;
		logic [15:0] tag;
		logic [15:0] skip;
	} tsr_entry_t;

	localparam logic [3:0] QUEUE_LIMIT_RESET = 4'd8;

endpackage

>>> hw/rtl/tsr_if.sv
interface tsr_in_if;
	logic        valid;
	logic        ready;
	logic        opcode;
	logic [31:0] seq_number;
	logic        syn_flag;
	logic        first_packet;
	logic [15:0] payload_length;
	logic [15:0] buffer_tag;

	modport source (output valid, opcode, seq_number, syn_flag, first_packet,
		payload_length, buffer_tag, input ready);
	modport sink (input valid, opcode, seq_number, syn_flag, first_packet,
		payload_length, buffer_tag, output ready);
endinterface

interface tsr_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [15:0] out_tag;
	logic [15:0] skip_bytes;
	logic [31:0] byte_count;
	logic [31:0] stream_offset;
	logic        accepted;
	logic        last;

	modport source (output valid, kind, out_tag, skip_bytes, byte_count, stream_offset,
		accepted, last, input ready);
	modport sink (input valid, kind, out_tag, skip_bytes, byte_count, stream_offset,
		accepted, last, output ready);
endinterface

>>> hw/rtl/tsr_alu.sv
module tsr_alu (
	input  logic [31:0] a,
	input  logic [31:0] b,
	output logic        lt,
	output logic        eq
);
	logic [31:0] diff;

	// serial compare mod 2^32
	assign diff = a - b;
	assign lt   = diff[31];
	assign eq   = (diff == 32'd0);
endmodule

>>> hw/rtl/tsr_table.sv
module tsr_table import tsr_pkg::*; #(
	parameter int SLOTS = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  tsr_tbl_op_t                op,
	input  logic [$clog2(SLOTS)-1:0]   pos,
	input  tsr_entry_t                 wr_entry,
	input  logic [$clog2(SLOTS)-1:0]   rd_idx,
	output tsr_entry_t                 rd_entry,
	output tsr_entry_t                 head,
	output logic [$clog2(SLOTS+1)-1:0] count
);
	localparam int CW = $clog2(SLOTS + 1);

	tsr_entry_t       entry_q [SLOTS];
	logic [CW-1:0]    count_q;

	assign rd_entry = entry_q[rd_idx];
	assign head     = entry_q[0];
	assign count    = count_q;

	always_ff @(posedge clk) begin
		for (int j = 0; j < SLOTS; j++) begin
			if (op == TBL_INSERT) begin
				if (j == int'(pos)) begin
					entry_q[j] <= wr_entry;
				end else if (j > int'(pos)) begin
					entry_q[j] <= entry_q[j-1];
				end
			end else if (op == TBL_POP && j < SLOTS - 1) begin
				entry_q[j] <= entry_q[j+1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			case (op)
				TBL_INSERT: count_q <= count_q + 1'b1;
				TBL_POP:    count_q <= count_q - 1'b1;
				default:    count_q <= count_q;
			endcase
		end
	end
endmodule

>>> hw/rtl/tcp_segment_reassembly.sv
// channel   dir  contents
// seg_in    in   opcode, seq_number, syn_flag, first_packet, payload_length, buffer_tag
// res_out   out  kind, out_tag, skip_bytes, byte_count, stream_offset, accepted, last
// cfg       in   cfg_we, cfg_wdata (queue_limit)
//
// one item at a time: each is classified, then held entries are scanned, popped or
// flushed one by one, all through the shared serial compare unit
// a result waits in the output register; a full one not yet taken stalls the sequencer
// reset clears state, counters and queue_limit (to 8); table contents need none
`include "tcp_segment_reassembly_defines.svh"

module tcp_segment_reassembly import tsr_pkg::*; #(
	parameter int SLOTS = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	tsr_in_if.sink       seg_in,
	tsr_out_if.source    res_out,
	input  logic         cfg_we,
	input  logic [3:0]   cfg_wdata
);
	localparam int IW = $clog2(SLOTS);
	localparam int CW = $clog2(SLOTS + 1);

	typedef enum logic [3:0] {
		ST_IDLE, ST_CLASS, ST_OLD, ST_SCAN, ST_POS, ST_POS2,
		ST_PLACE, ST_GAP, ST_CHECK, ST_STATUS, ST_FLUSH
	} state_t;

	state_t       state_q;
	logic         flush_q, acc_q, limchk_q, syn_q;
	logic [31:0]  seq_q, end_q, ne_q, bo_q, cend_q;
	logic [15:0]  len_q, tag_q, skip_q;
	logic [CW-1:0] i_q;
	logic [3:0]   ql_q;

	logic         out_valid_q, out_acc_q, out_last_q;
	logic [1:0]   out_kind_q;
	logic [15:0]  out_tag_q, out_skip_q;
	logic [31:0]  out_cnt_q, out_off_q;

	tsr_tbl_op_t   tbl_op;
	tsr_entry_t    wr_entry, rd_entry, head;
	logic [CW-1:0] count;
	logic [IW-1:0] rd_idx;
	logic [31:0]   alu_a, alu_b, diff;
	logic          alu_lt, alu_eq, can_emit, head_due;

	assign can_emit = !out_valid_q || res_out.ready;
	assign seg_in.ready = (state_q == ST_IDLE);
	assign rd_idx   = IW'(i_q - 1'b1);
	assign wr_entry = '{seq: seq_q, len: len_q, tag: tag_q, skip: skip_q};
	assign head_due = (count != '0) && !alu_lt;
	assign diff     = cend_q - seq_q;

	always_comb begin
		alu_a = seq_q;
		alu_b = ne_q;
		case (state_q)
			ST_OLD:            begin alu_a = ne_q; alu_b = end_q; end
			ST_SCAN:           begin alu_a = seq_q; alu_b = rd_entry.seq; end
			ST_POS2:           begin alu_a = seq_q; alu_b = cend_q; end
			ST_CHECK, ST_GAP:  begin alu_a = ne_q; alu_b = head.seq; end
			default:           begin alu_a = seq_q; alu_b = ne_q; end
		endcase
	end

	tsr_alu u_alu (.a(alu_a), .b(alu_b), .lt(alu_lt), .eq(alu_eq));

	always_comb begin
		tbl_op = TBL_NONE;
		case (state_q)
			ST_CHECK: begin
				if (head_due && (head.seq != ne_q || can_emit))
					tbl_op = TBL_POP;
			end
			ST_PLACE: begin
				if (count != CW'(SLOTS))
					tbl_op = TBL_INSERT;
			end
			default: tbl_op = TBL_NONE;
		endcase
	end

	tsr_table #(.SLOTS(SLOTS)) u_table (
		.clk(clk), .arst_n(arst_n), .op(tbl_op), .pos(IW'(i_q)), .wr_entry(wr_entry),
		.rd_idx(rd_idx), .rd_entry(rd_entry), .head(head), .count(count)
	);

	assign res_out.valid         = out_valid_q;
	assign res_out.kind          = out_kind_q;
	assign res_out.out_tag       = out_tag_q;
	assign res_out.skip_bytes    = out_skip_q;
	assign res_out.byte_count    = out_cnt_q;
	assign res_out.stream_offset = out_off_q;
	assign res_out.accepted      = out_acc_q;
	assign res_out.last          = out_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			flush_q     <= 1'b0;
			acc_q       <= 1'b0;
			limchk_q    <= 1'b0;
			syn_q       <= 1'b0;
			ne_q        <= '0;
			bo_q        <= '0;
			i_q         <= '0;
			ql_q        <= QUEUE_LIMIT_RESET;
			out_valid_q <= 1'b0;
			seq_q <= '0; end_q <= '0; cend_q <= '0;
			len_q <= '0; tag_q <= '0; skip_q <= '0;
			out_acc_q <= 1'b0; out_last_q <= 1'b0; out_kind_q <= KIND_DATA;
			out_tag_q <= '0; out_skip_q <= '0; out_cnt_q <= '0; out_off_q <= '0;
		end else begin
			if (cfg_we)
				ql_q <= cfg_wdata;
			if (res_out.ready)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (seg_in.valid) begin
						seq_q    <= seg_in.seq_number;
						len_q    <= seg_in.payload_length;
						tag_q    <= seg_in.buffer_tag;
						syn_q    <= seg_in.syn_flag;
						end_q    <= seg_in.seq_number + 32'(seg_in.payload_length);
						skip_q   <= '0;
						acc_q    <= 1'b0;
						limchk_q <= 1'b0;
						if (seg_in.opcode == OP_EOS) begin
							flush_q <= 1'b1;
							state_q <= ST_FLUSH;
						end else begin
							flush_q <= 1'b0;
							if (seg_in.first_packet)
								ne_q <= seg_in.seq_number + 32'(seg_in.syn_flag);
							state_q <= ST_CLASS;
						end
					end
				end
				ST_CLASS: begin
					if (len_q == '0 || syn_q) begin
						state_q <= ST_STATUS;
					end else if (alu_eq) begin
						if (can_emit) begin
							out_valid_q <= 1'b1;
							out_kind_q  <= KIND_DATA;
							out_tag_q   <= tag_q;
							out_skip_q  <= '0;
							out_cnt_q   <= 32'(len_q);
							out_off_q   <= bo_q;
							out_acc_q   <= 1'b0;
							out_last_q  <= 1'b0;
							ne_q        <= ne_q + 32'(len_q);
							bo_q        <= bo_q + 32'(len_q);
							acc_q       <= 1'b1;
							state_q     <= ST_CHECK;
						end
					end else if (alu_lt) begin
						state_q <= ST_OLD;
					end else if (count == '0) begin
						i_q     <= '0;
						state_q <= ST_PLACE;
					end else begin
						i_q      <= count;
						limchk_q <= 1'b1;
						state_q  <= ST_SCAN;
					end
				end
				ST_OLD: begin
					if (!alu_lt) begin
						state_q <= ST_STATUS;
					end else if (can_emit) begin
						out_valid_q <= 1'b1;
						out_kind_q  <= KIND_DATA;
						out_tag_q   <= tag_q;
						out_skip_q  <= 16'(ne_q - seq_q);
						out_cnt_q   <= end_q - ne_q;
						out_off_q   <= bo_q;
						out_acc_q   <= 1'b0;
						out_last_q  <= 1'b0;
						bo_q        <= bo_q + (end_q - ne_q);
						ne_q        <= end_q;
						acc_q       <= 1'b1;
						state_q     <= ST_CHECK;
					end
				end
				ST_SCAN: begin
					if (i_q != '0 && alu_lt) begin
						if ((rd_entry.seq - end_q) >> 31 != 32'd0) begin
							len_q <= 16'(rd_entry.seq - seq_q);
							end_q <= rd_entry.seq;
						end
						i_q <= i_q - 1'b1;
					end else begin
						state_q <= ST_POS;
					end
				end
				ST_POS: begin
					if (i_q == '0) begin
						state_q <= ST_PLACE;
					end else begin
						cend_q  <= rd_entry.seq + 32'(rd_entry.len);
						state_q <= ST_POS2;
					end
				end
				ST_POS2: begin
					if (!alu_lt) begin
						state_q <= ST_PLACE;
					end else if (seq_q == rd_entry.seq && len_q == rd_entry.len) begin
						acc_q   <= 1'b1;
						state_q <= ST_STATUS;
					end else if (diff < 32'(len_q)) begin
						seq_q   <= cend_q;
						len_q   <= len_q - diff[15:0];
						skip_q  <= diff[15:0];
						state_q <= ST_PLACE;
					end else begin
						state_q <= ST_STATUS;
					end
				end
				ST_PLACE: begin
					if (count == CW'(SLOTS)) begin
						state_q <= ST_STATUS;
					end else begin
						acc_q <= 1'b1;
						if (limchk_q && ((8'(count) + 8'd1) > 8'(ql_q)))
							state_q <= ST_GAP;
						else
							state_q <= ST_STATUS;
					end
				end
				ST_GAP: begin
					if (count != '0 && alu_lt) begin
						if (can_emit) begin
							out_valid_q <= 1'b1;
							out_kind_q  <= KIND_GAP;
							out_tag_q   <= '0;
							out_skip_q  <= '0;
							out_cnt_q   <= head.seq - ne_q;
							out_off_q   <= bo_q;
							out_acc_q   <= 1'b0;
							out_last_q  <= 1'b0;
							bo_q        <= bo_q + (head.seq - ne_q);
							ne_q        <= head.seq;
							state_q     <= ST_CHECK;
						end
					end else begin
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					if (head_due) begin
						if (head.seq == ne_q && can_emit) begin
							out_valid_q <= 1'b1;
							out_kind_q  <= KIND_DATA;
							out_tag_q   <= head.tag;
							out_skip_q  <= head.skip;
							out_cnt_q   <= 32'(head.len);
							out_off_q   <= bo_q;
							out_acc_q   <= 1'b0;
							out_last_q  <= 1'b0;
							ne_q        <= ne_q + 32'(head.len);
							bo_q        <= bo_q + 32'(head.len);
						end
					end else begin
						state_q <= flush_q ? ST_FLUSH : ST_STATUS;
					end
				end
				ST_STATUS: begin
					if (can_emit) begin
						out_valid_q <= 1'b1;
						out_kind_q  <= KIND_STATUS;
						out_tag_q   <= '0;
						out_skip_q  <= '0;
						out_cnt_q   <= '0;
						out_off_q   <= '0;
						out_acc_q   <= acc_q;
						out_last_q  <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				ST_FLUSH: begin
					if (count != '0) begin
						state_q <= ST_GAP;
					end else if (can_emit) begin
						out_valid_q <= 1'b1;
						out_kind_q  <= KIND_EOS;
						out_tag_q   <= '0;
						out_skip_q  <= '0;
						out_cnt_q   <= '0;
						out_off_q   <= bo_q;
						out_acc_q   <= 1'b0;
						out_last_q  <= 1'b1;
						bo_q        <= '0;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`TSR_ASSERT(a_count_bound, clk, arst_n, (count <= CW'(SLOTS)))
	`TSR_ASSERT_NEXT(a_idle_table_stable, clk, arst_n, (state_q == ST_IDLE), $stable(count))
	`TSR_ASSERT(a_eos_last, clk, arst_n, (!(out_valid_q && out_kind_q == KIND_EOS) || out_last_q))
endmodule
